[src/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  localparam int CU_W        = 21;   // code unit / scalar width
  localparam int CNT_W       = 20;   // byte counter and capacity width
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int MAX_BYTES   = 8;    // byte slots per queue entry
  localparam int IDX_W       = $clog2(MAX_BYTES);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [CU_W-1:0]  CP_HI_FIRST   = 21'h00D800;
  localparam logic [CU_W-1:0]  CP_HI_LAST    = 21'h00DBFF;
  localparam logic [CU_W-1:0]  CP_LO_FIRST   = 21'h00DC00;
  localparam logic [CU_W-1:0]  CP_LO_LAST    = 21'h00DFFF;
  localparam logic [CU_W-1:0]  CP_SUPP_BASE  = 21'h010000;
  localparam logic [CU_W-1:0]  CP_LIM_1B     = 21'h000080;
  localparam logic [CU_W-1:0]  CP_LIM_2B     = 21'h000800;
  localparam logic [CNT_W-1:0] COUNT_MAX     = 20'hFFFFF;

  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;

  // result kind on tuser
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary status
  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_TOO_SMALL = 1'b1;

  typedef struct packed {
    logic [3:0][7:0] b;     // b[0] is sent first
    logic [2:0]      len;   // 1..4
  } enc_t;

  // One queue entry: all results caused by one accepted item.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          nbytes;   // 0..7 data bytes
    logic                      summ;     // summary result follows bytes
    logic                      status;
    logic [CNT_W-1:0]          total;
  } cmd_t;

  function automatic enc_t enc_utf8_char(input logic [CU_W-1:0] cp);
    enc_t e;
    e = '0;
    if (cp < CP_LIM_1B) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < CP_LIM_2B) begin
      e.b[0] = {LEAD2_TAG, cp[10:6]};
      e.b[1] = {CONT_TAG, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < CP_SUPP_BASE) begin
      e.b[0] = {LEAD3_TAG, cp[15:12]};
      e.b[1] = {CONT_TAG, cp[11:6]};
      e.b[2] = {CONT_TAG, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {LEAD4_TAG, cp[20:18]};
      e.b[1] = {CONT_TAG, cp[17:12]};
      e.b[2] = {CONT_TAG, cp[11:6]};
      e.b[3] = {CONT_TAG, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

[src/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, checks capacity and builds one
// queue entry per item that has anything to send.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front import u16u8_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  output cmd_t                  cmd,
  output logic                  cmd_valid,
  input  logic                  cmd_ready
);

  logic [CNT_W-1:0] cap_r;
  logic             pend_r, pend_nxt;
  logic [9:0]       ph_r, ph_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic [CU_W-1:0]  cu, cp_a;
  logic             is_high, is_low, va, vb, cap0;
  enc_t             enc_a, enc_b;
  logic [2:0]       len_a_m, len_b_m, len_a_e, len_b_e;
  logic [3:0]       len_ab;
  logic [CNT_W:0]   sum_a, sum_ab;
  logic             ovf_a, ovf_b, emit_a, emit_b;
  logic [IDX_W-1:0] rel;
  logic             accept;

  assign cu      = in_tdata[CU_W-1:0];
  assign is_high = (cu >= CP_HI_FIRST) && (cu <= CP_HI_LAST);
  assign is_low  = (cu >= CP_LO_FIRST) && (cu <= CP_LO_LAST);
  assign cap0    = (cap_r == '0);
  assign accept  = in_tvalid && in_tready;
  assign in_tready = cmd_ready;

  always_comb begin
    // char A: the held high surrogate, alone or joined with this unit
    va = pend_r;
    if (pend_r && is_low) begin
      cp_a = CP_SUPP_BASE + {1'b0, ph_r, cu[9:0]};
    end else begin
      cp_a = {5'd0, HI_SURR_TAG, ph_r};
    end
    // char B: this unit, unless consumed by the pair or held back
    vb = !(pend_r && is_low) && !(is_high && !in_tlast);

    enc_a = enc_utf8_char(cp_a);
    enc_b = enc_utf8_char(cu);

    len_a_m = va ? enc_a.len : 3'd0;
    len_b_m = vb ? enc_b.len : 3'd0;
    len_ab  = {1'b0, len_a_m} + {1'b0, len_b_m};
    sum_a   = {1'b0, count_r} + (CNT_W+1)'(len_a_m);
    sum_ab  = {1'b0, count_r} + (CNT_W+1)'(len_ab);

    ovf_a  = ovf_r || (va && (sum_a > {1'b0, cap_r}));
    emit_a = va && !cap0 && !ovf_a;
    ovf_b  = ovf_a || (vb && (sum_ab > {1'b0, cap_r}));
    emit_b = vb && !cap0 && !ovf_b;

    len_a_e = emit_a ? enc_a.len : 3'd0;
    len_b_e = emit_b ? enc_b.len : 3'd0;

    if (cap0) begin
      ovf_nxt   = ovf_r;
      count_nxt = sum_ab[CNT_W] ? COUNT_MAX : sum_ab[CNT_W-1:0];
    end else begin
      ovf_nxt   = ovf_b;
      count_nxt = count_r + CNT_W'(len_a_e) + CNT_W'(len_b_e);
    end

    for (int k = 0; k < MAX_BYTES; k++) begin
      rel = IDX_W'(k) - IDX_W'(len_a_e);
      if (IDX_W'(k) < IDX_W'(len_a_e)) begin
        cmd.bytes[k] = enc_a.b[k[1:0]];
      end else begin
        cmd.bytes[k] = enc_b.b[rel[1:0]];
      end
    end
    cmd.nbytes = IDX_W'(len_a_e) + IDX_W'(len_b_e);
    cmd.summ   = in_tlast;
    cmd.status = ovf_nxt ? STAT_TOO_SMALL : STAT_OK;
    cmd.total  = ovf_nxt ? '0 : count_nxt;

    pend_nxt = is_high && !in_tlast && !(pend_r && is_low);
    ph_nxt   = pend_nxt ? cu[9:0] : 10'd0;
  end

  assign cmd_valid = in_tvalid && ((cmd.nbytes != '0) || in_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      pend_r  <= 1'b0;
      ph_r    <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_tlast) begin
          pend_r  <= 1'b0;
          ph_r    <= '0;
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          pend_r  <= pend_nxt;
          ph_r    <= ph_nxt;
          count_r <= count_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/u16u8_fifo.sv]
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of per-item entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_fifo import u16u8_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t wr_data,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_data,
  output logic rd_valid,
  input  logic rd_pop
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               push, pop;

  assign wr_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head entry to the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back import u16u8_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   head,
  input  logic                   head_valid,
  output logic                   head_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [IDX_W-1:0]       idx_r;
  logic                   vld_r;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic                   user_r, user_nxt;
  logic                   last_r, last_nxt;
  logic                   load, is_byte;

  assign load     = head_valid && (!vld_r || out_tready);
  assign is_byte  = (idx_r < head.nbytes);
  assign head_pop = load && last_nxt;

  always_comb begin
    if (is_byte) begin
      data_nxt = {(OUT_TDATA_W-8)'(0), head.bytes[idx_r]};
      user_nxt = KIND_DATA;
      last_nxt = (idx_r == head.nbytes - 1'b1) && !head.summ;
    end else begin
      data_nxt = {(OUT_TDATA_W-CNT_W-9)'(0), head.total, head.status, 8'd0};
      user_nxt = KIND_SUMMARY;
      last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= last_nxt ? '0 : idx_r + 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

[src/utf16_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Streams UTF-16 code units (or full scalars) in, UTF-8 bytes and an
// end-of-string summary out.
// ----------------------------------------------------------------------------
// The block takes one code unit per item and returns one result per cycle on
// the output stream while out_tready allows: the UTF-8 bytes of each
// finished character, and after the unit flagged tlast a summary carrying
// status and byte count. A high surrogate that is not the last unit is held
// until the next unit; a following low surrogate makes one 4-byte character,
// anything else flushes the held unit as 3 bytes. With a nonzero capacity,
// bytes are sent per character only while they fit; the first character
// that does not fit sets the too-small status and mutes the rest of the
// string (summary total then reads 0). Capacity 0 only counts. An input item
// is accepted whenever the 2-entry queue has room, even while earlier items
// are still being sent; the output side sends the results each item caused
// (0 to 8) one by one, so sustained throughput is set by the output port.
// The first result of an item passes through the queue and the output
// register before it is presented. Write cfg_wdata only while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: output buffer capacity in bytes, 0 = count only
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [20:0] code_unit, [23:21] zero
  input  logic                   in_tlast,   // last_unit
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [8] status,
                                             // [28:9] total_bytes, [31:29] zero
  output logic                   out_tuser,  // kind: 0 data byte, 1 summary
  output logic                   out_tlast   // last_result of the item
);

  cmd_t fr_cmd, q_head;
  logic fr_valid, fr_ready;
  logic q_valid, q_pop;

  // front: surrogate pairing, encoding, capacity check, per-string state
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (fr_cmd),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready)
  );

  // decoupling queue; items that produce no result never enter it
  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (fr_cmd),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .rd_data  (q_head),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  // back: serializes each entry into bytes plus optional summary
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .head_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[src/u16u8_checker.sv]
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the result stream of the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // summary always closes the item's results
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("summary not marked last");

  // data bytes carry no status or count
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:8] == 24'd0)
    else $error("data byte with summary fields set");

  // summaries carry a zero byte field; an overflow summary also reports zero bytes
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0
      && (!out_tdata[8] || out_tdata[28:9] == 20'd0))
    else $error("bad summary payload");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[sim/tb_utf16_to_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A short table of
// directed items covers the encoding-length limits, the surrogate pairing
// rules, count-only counting, buffer overflow and a capacity change in the
// middle of a string. Random strings under several capacities follow.
// Every result is checked against a behavioral copy of the transcoder.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder import u16u8_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int SETTLE      = 8;     // idle cycles before a capacity write
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off

  // One expected item on the result stream.
  typedef struct packed {
    logic [7:0]       data;
    logic             kind;
    logic             status;
    logic [CNT_W-1:0] total;
    logic             tail;    // last result caused by the input item
  } utf8_result_t;

  typedef enum logic [1:0] {ROW_UNIT, ROW_CFG} row_op_t;

  // Directed table row. For ROW_CFG the value is the new capacity.
  // Rows with typed set carry a hand-written summary expectation.
  typedef struct packed {
    row_op_t          op;
    logic [CU_W-1:0]  value;
    logic             last;
    logic             typed;
    logic             status;
    logic [CNT_W-1:0] total;
  } dir_row_t;

  localparam int NROWS = 27;

  localparam dir_row_t DIR_ROWS [NROWS] = '{
    // capacity is 0 out of reset: count only, one byte counted
    '{ROW_UNIT, 21'h000041, 1'b1, 1'b1, STAT_OK,        20'd1},
    '{ROW_CFG,  21'h0FFFFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    // encoding-length boundaries
    '{ROW_UNIT, 21'h000000, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h00007F, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000080, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h0007FF, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000800, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h00FFFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    // high/low pair joined into one 4-byte char
    '{ROW_UNIT, 21'h00D800, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h00DFFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    // held high flushed alone by a plain unit
    '{ROW_UNIT, 21'h00DBFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000041, 1'b0, 1'b0, STAT_OK,        20'd0},
    // lone low, direct scalars, out-of-range lead byte F7
    '{ROW_UNIT, 21'h00DC00, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h010000, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h10FFFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h1FFFFF, 1'b0, 1'b0, STAT_OK,        20'd0},
    // high after high, then a high as the last unit
    '{ROW_UNIT, 21'h00DABC, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h00DBFF, 1'b1, 1'b0, STAT_OK,        20'd0},
    // capacity 5: exact fill, then overflow mutes the rest
    '{ROW_CFG,  21'h000005, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000041, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h010000, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000042, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000043, 1'b1, 1'b1, STAT_TOO_SMALL, 20'd0},
    // capacity switched to count-only in the middle of a string
    '{ROW_CFG,  21'h000003, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000041, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_CFG,  21'h000000, 1'b0, 1'b0, STAT_OK,        20'd0},
    '{ROW_UNIT, 21'h000800, 1'b1, 1'b1, STAT_OK,        20'd4}
  };

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time 0
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [20:0] code_unit, [23:21] zero
  logic                   in_tlast = 1'b0; // last_unit
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [7:0] out_byte, [8] status,
                                           // [28:9] total_bytes, [31:29] zero
  logic                   out_tuser;       // kind
  logic                   out_tlast;       // last_result

  utf16_to_utf8_transcoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Transcoder mirror: capacity, held high surrogate, byte count, overflow
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] capacity     = '0;
  logic             held_valid   = 1'b0;
  logic [9:0]       held_low10   = '0;
  logic [CNT_W-1:0] bytes_so_far = '0;
  logic             too_small    = 1'b0;

  utf8_result_t utf8_due [$];   // results still to come, oldest first

  int errors          = 0;
  int units_sent      = 0;
  int results_checked = 0;
  int strings_done    = 0;
  int overflow_count  = 0;
  int saturated_count = 0;
  int cfg_writes      = 0;

  // sender pacing
  int burst_left  = 0;
  bit sender_gaps = 1'b1;
  bit hold_request = 1'b0;

  // Encode one scalar and apply the capacity rules: all bytes of a char or none.
  task automatic encode_scalar(input logic [CU_W-1:0] cp);
    logic [7:0]   seq [4];
    int           len;
    int           k;
    utf8_result_t r;
    if (cp < CP_LIM_1B) begin
      seq[0] = cp[7:0];
      len = 1;
    end else if (cp < CP_LIM_2B) begin
      seq[0] = 8'hC0 | cp[10:6];
      seq[1] = 8'h80 | cp[5:0];
      len = 2;
    end else if (cp < CP_SUPP_BASE) begin
      seq[0] = 8'hE0 | cp[15:12];
      seq[1] = 8'h80 | cp[11:6];
      seq[2] = 8'h80 | cp[5:0];
      len = 3;
    end else begin
      seq[0] = 8'hF0 | cp[20:18];
      seq[1] = 8'h80 | cp[17:12];
      seq[2] = 8'h80 | cp[11:6];
      seq[3] = 8'h80 | cp[5:0];
      len = 4;
    end
    if (capacity == '0) begin
      // count only, saturating
      if (int'(bytes_so_far) + len > int'(COUNT_MAX)) bytes_so_far = COUNT_MAX;
      else bytes_so_far = CNT_W'(int'(bytes_so_far) + len);
    end else if (!too_small) begin
      if (int'(bytes_so_far) + len > int'(capacity)) begin
        too_small = 1'b1;
      end else begin
        for (k = 0; k < len; k++) begin
          r = '{data: seq[k], kind: KIND_DATA, status: STAT_OK, total: '0, tail: 1'b0};
          utf8_due.push_back(r);
        end
        bytes_so_far = CNT_W'(int'(bytes_so_far) + len);
      end
    end
  endtask

  // Apply one accepted code unit to the mirror and queue what it produces.
  task automatic transcode_unit(input logic [CU_W-1:0] cu, input logic last);
    logic         is_high;
    logic         is_low;
    logic         done;
    int           before_n;
    utf8_result_t r;
    before_n = utf8_due.size();
    is_high  = (cu >= CP_HI_FIRST) && (cu <= CP_HI_LAST);
    is_low   = (cu >= CP_LO_FIRST) && (cu <= CP_LO_LAST);
    done     = 1'b0;
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_low) begin
        encode_scalar(CP_SUPP_BASE + {held_low10, 10'b0} + (cu - CP_LO_FIRST));
        done = 1'b1;
      end else begin
        encode_scalar(CP_HI_FIRST + held_low10);
      end
      held_low10 = '0;
    end
    if (!done) begin
      if (is_high && !last) begin
        held_valid = 1'b1;
        held_low10 = cu[9:0];
      end else begin
        encode_scalar(cu);
      end
    end
    if (last) begin
      r = '{data: 8'h00, kind: KIND_SUMMARY,
            status: too_small ? STAT_TOO_SMALL : STAT_OK,
            total: too_small ? '0 : bytes_so_far, tail: 1'b0};
      utf8_due.push_back(r);
      strings_done++;
      if (too_small) overflow_count++;
      if (!too_small && bytes_so_far == COUNT_MAX) saturated_count++;
      held_valid   = 1'b0;
      held_low10   = '0;
      bytes_so_far = '0;
      too_small    = 1'b0;
    end
    // flag the final result of this item
    if (utf8_due.size() > before_n) begin
      r = utf8_due.pop_back();
      r.tail = 1'b1;
      utf8_due.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  task automatic send_unit(input logic [CU_W-1:0] cu, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CU_W){1'b0}}, cu};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    transcode_unit(cu, last);
    units_sent++;
  endtask

  // Stop offering and wait until every expected result is out, then settle.
  task automatic drain(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (utf8_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Capacity writes only while the block is idle; a held surrogate or
  // a muted char may still be in flight, hence the settle cycles.
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain(SETTLE);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    capacity = value;
    cfg_writes++;
  endtask

  // One random string; surrogate pairs take two units.
  task automatic send_random_string(output int n_units);
    logic [CU_W-1:0] units [$];
    int              len;
    int              i;
    len = $urandom_range(1, 10);
    units.delete();
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1: units.push_back(CU_W'($urandom_range(0, 16'h007F)));
        2:    units.push_back(CU_W'($urandom_range(16'h0080, 16'h07FF)));
        3:    units.push_back(CU_W'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                                        : $urandom_range(16'hE000, 16'hFFFF)));
        4, 5: begin
          units.push_back(CU_W'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
          units.push_back(CU_W'($urandom_range(CP_LO_FIRST, CP_LO_LAST)));
        end
        6:    units.push_back(CU_W'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
        7:    units.push_back(CU_W'($urandom_range(CP_LO_FIRST, CP_LO_LAST)));
        8:    units.push_back(CU_W'($urandom_range(21'h010000, 21'h10FFFF)));
        default: units.push_back(CU_W'($urandom()));
      endcase
    end
    sender_gaps = ($urandom_range(0, 3) != 0);
    for (i = 0; i < units.size(); i++)
      send_unit(units[i], i == units.size() - 1);
    n_units = units.size();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready pattern switches between random ready rates; a hold
  // request keeps ready low for a long stretch so the input side backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode_left;
    int ready_pct;
    int hold_left;
    mode_left = 0;
    ready_pct = 100;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 40;
            default: ready_pct = 20;
          endcase
        end
        mode_left--;
        out_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $realtime, what, got, want, results_checked);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    utf8_result_t got;
    utf8_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{data: out_tdata[7:0], kind: out_tuser, status: out_tdata[8],
              total: out_tdata[28:9], tail: out_tlast};
      if (utf8_due.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = utf8_due.pop_front();
        if (got.data != want.data)     report_mismatch("out_byte", got.data, want.data);
        if (got.kind != want.kind)     report_mismatch("kind", got.kind, want.kind);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.total != want.total)   report_mismatch("total_bytes", got.total, want.total);
        if (got.tail != want.tail)     report_mismatch("last_result", got.tail, want.tail);
      end
      results_checked++;
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
               $realtime, quiet, utf8_due.size());
      $display("tb_utf16_to_utf8_transcoder: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int           i;
    int           phase;
    int           sent;
    int           n;
    logic [CNT_W-1:0] cap_value;
    bit           hold_done;
    utf8_result_t typed_sum;

    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < NROWS; i++) begin
      if (DIR_ROWS[i].op == ROW_CFG) begin
        write_capacity(DIR_ROWS[i].value[CNT_W-1:0]);
      end else begin
        send_unit(DIR_ROWS[i].value, DIR_ROWS[i].last);
        if (DIR_ROWS[i].typed) begin
          // summary typed in by hand replaces the mirror's one
          typed_sum = utf8_due.pop_back();
          typed_sum = '{data: 8'h00, kind: KIND_SUMMARY, status: DIR_ROWS[i].status,
                        total: DIR_ROWS[i].total, tail: 1'b1};
          utf8_due.push_back(typed_sum);
        end
      end
    end

    // random strings under a spread of capacities, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       cap_value = COUNT_MAX;
        1:       cap_value = CNT_W'($urandom_range(1, 40));
        2:       cap_value = '0;
        3:       cap_value = 1;
        4:       cap_value = CNT_W'($urandom());
        default: cap_value = CNT_W'($urandom_range(20, 200));
      endcase
      write_capacity(cap_value);
      sent = 0;
      while (sent < 28) begin
        send_random_string(n);
        sent += n;
        // long receiver hold-off while the sender keeps going
        if (phase == 0 && !hold_done && sent >= 6) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
      end
    end

    drain(20);
    $display("covered %0d code units in %0d strings, %0d results checked",
             units_sent, strings_done, results_checked);
    $display("%0d capacity writes, %0d overflowed strings, %0d saturated counts",
             cfg_writes, overflow_count, saturated_count);
    if (errors == 0) begin
      $display("tb_utf16_to_utf8_transcoder: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_utf16_to_utf8_transcoder: FAIL");
    end
    $finish;
  end

endmodule
